### rtl/core/mtss_pkg.sv
// Shared types, constants and the quarter-wave sine table of the multi-tone sine synthesizer.
package mtss_pkg;

	// Number of tones, sine table size and phase accumulator width.
	localparam int NUM_TONES  = 4;
	localparam int TABLE_BITS = 10;
	localparam int PHASE_BITS = 32;

	// Field widths.
	localparam int LEVEL_W    = 16;
	localparam int SAMPLE_W   = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	// Sine table geometry: one quarter wave plus its end point.
	localparam int QUARTER = 2 ** (TABLE_BITS - 2);
	localparam int X_W     = TABLE_BITS - 1;

	// Arithmetic widths: unsigned level times signed sine, then the sum over all tones.
	localparam int PROD_W = LEVEL_W + SAMPLE_W + 1;
	localparam int SUM_W  = PROD_W + $clog2(NUM_TONES + 1);

	// The sum is divided by 2^FRAC_BITS with truncation toward zero.
	localparam int FRAC_BITS = 15;

	// Register kinds: bit 0 of the register index selects step or level, the upper bits the tone.
	localparam logic REG_KIND_STEP  = 1'b0;
	localparam logic REG_KIND_LEVEL = 1'b1;

	// Polynomial constants used to build the sine table.
	localparam longint Q30_ONE  = 64'sd1073741824;
	localparam longint AMP_FULL = 64'sd32767;
	localparam longint SIN_COEF [5] = '{
		64'sd1686629713, -64'sd693598670, 64'sd85569306, -64'sd5026995, 64'sd172272
	};

	typedef logic [SAMPLE_W-2:0] sine_mag_t;
	typedef sine_mag_t sine_rom_t [QUARTER + 1];

	// Token that walks down the cell row, one cell per cycle.
	typedef struct packed {
		logic valid;
		logic restart;
	} tone_tok_t;

	// Configuration strobes and data for one tone cell.
	typedef struct packed {
		logic                  step_we;
		logic                  level_we;
		logic [CFG_DATA_W-1:0] data;
	} cell_cfg_t;

	// Magnitude of sin(pi/2 * x / QUARTER) scaled to full amplitude.
	function automatic sine_mag_t sine_mag(int unsigned x);
		longint t;
		longint t2;
		longint acc;
		longint s;
		longint mag;
		int     i;
		t   = longint'(x) <<< (32 - TABLE_BITS);
		t2  = (t * t) / Q30_ONE;
		acc = SIN_COEF[4];
		for (i = 3; i >= 0; i--) begin
			acc = SIN_COEF[i] + (acc * t2) / Q30_ONE;
		end
		s = (acc * t) / Q30_ONE;
		if (s < 0) begin
			s = 0;
		end
		mag = (s * AMP_FULL + (Q30_ONE / 2)) / Q30_ONE;
		if (mag > AMP_FULL) begin
			mag = AMP_FULL;
		end
		return sine_mag_t'(mag);
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		int        i;
		for (i = 0; i <= QUARTER; i++) begin
			rom[i] = sine_mag(i);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

### rtl/core/mtss_tick_if.sv
// Request channel that carries one sample tick with its restart flag.
interface mtss_tick_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

### rtl/core/mtss_sample_if.sv
// Request channel that carries one PCM sample with its clip flag.
interface mtss_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pcm_sample;
	logic               clipped;

	modport source (output valid, output pcm_sample, output clipped, input ready);
	modport sink (input valid, input pcm_sample, input clipped, output ready);
endinterface

### rtl/core/mtss_tone_cell.sv
// One tone cell: phase accumulator, sine lookup and multiply-accumulate into the running sum.
module mtss_tone_cell (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mtss_pkg::cell_cfg_t                   cfg,
	input  mtss_pkg::tone_tok_t                   tok_in,
	output mtss_pkg::tone_tok_t                   tok_out,
	input  logic signed [mtss_pkg::SUM_W-1:0]     sum_in,
	output logic signed [mtss_pkg::SUM_W-1:0]     sum_out,
	output logic                                  sum_vld
);
	import mtss_pkg::*;

	logic [PHASE_BITS-1:0]      step_q;
	logic [LEVEL_W-1:0]         level_q;
	logic [PHASE_BITS-1:0]      phase_q;
	logic [PHASE_BITS-1:0]      phase_use;
	logic [TABLE_BITS-1:0]      tab_idx;
	logic [1:0]                 quad;
	logic [X_W-1:0]             x_lin;
	logic [X_W-1:0]             x_idx;
	sine_mag_t                  mag;
	logic signed [SAMPLE_W-1:0] sine_s1;
	tone_tok_t                  tok_s1;
	logic signed [PROD_W-1:0]   prod;
	logic signed [SUM_W-1:0]    sum_q;
	logic                       sum_vld_q;

	// A restart request makes this sample use phase zero.
	assign phase_use = tok_in.restart ? '0 : phase_q;
	assign tab_idx   = phase_use[PHASE_BITS-1 -: TABLE_BITS];
	assign quad      = tab_idx[TABLE_BITS-1 -: 2];
	assign x_lin     = {1'b0, tab_idx[TABLE_BITS-3:0]};
	// Odd quadrants run the quarter wave backward.
	assign x_idx     = quad[0] ? (X_W'(QUARTER) - x_lin) : x_lin;
	assign mag       = SINE_ROM[x_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			level_q <= '0;
			phase_q <= '0;
		end else begin
			if (cfg.step_we) begin
				step_q <= cfg.data[PHASE_BITS-1:0];
			end
			if (cfg.level_we) begin
				level_q <= cfg.data[LEVEL_W-1:0];
			end
			if (tok_in.valid) begin
				phase_q <= phase_use + step_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.valid) begin
			sine_s1 <= quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

	assign prod = $signed({1'b0, level_q}) * sine_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1    <= '0;
			sum_vld_q <= 1'b0;
		end else begin
			tok_s1    <= tok_in;
			sum_vld_q <= tok_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_s1.valid) begin
			sum_q <= sum_in + SUM_W'(prod);
		end
	end

	assign tok_out = tok_s1;
	assign sum_out = sum_q;
	assign sum_vld = sum_vld_q;

endmodule

### rtl/core/multi_tone_sine_synth_unit.sv
// Top level of the multi-tone sine synthesizer: tone cell row, result scaling and output register.
//
//   Channel   Role    Payload                      Notes
//   tick      sink    restart                      one request per PCM sample
//   sample    source  pcm_sample, clipped          one request per tick request
//   cfg_*     write   cfg_index, cfg_wdata         step and level of each tone
//
// Each accepted tick request reaches the output register by way of the token register and
// the row of tone cells, carried by the token that walks through them.
// One tick is in flight at a time, so a new tick is taken only after the last one is loaded;
// tick.ready is high whenever the cell row is empty.
// A finished sample waits in the output register while the next tick already runs;
// if that register is still full, the new sum is held in the last cell and tick.ready stays low.
// Reset clears all phases, steps and levels; configuration must be written while idle (unchecked).
module multi_tone_sine_synth_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	mtss_tick_if.sink                           tick,
	mtss_sample_if.source                       sample,
	input  logic                                cfg_we,
	input  logic [mtss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mtss_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import mtss_pkg::*;

	localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'((2 ** FRAC_BITS) - 1);
	localparam logic signed [SUM_W-1:0] SAMPLE_MAX =
		{{(SUM_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAMPLE_MIN =
		{{(SUM_W - SAMPLE_W + 1){1'b1}}, {(SAMPLE_W - 1){1'b0}}};

	tone_tok_t               tok0_q;
	tone_tok_t               tok [NUM_TONES + 1];
	logic signed [SUM_W-1:0] sum [NUM_TONES + 1];
	logic                    sum_vld [NUM_TONES];
	cell_cfg_t               cell_cfg [NUM_TONES];

	logic                    busy_q;
	logic                    res_pend_q;
	logic                    res_avail;
	logic                    out_load;
	logic                    out_vld_q;
	logic signed [SAMPLE_W-1:0] pcm_q;
	logic                    clip_q;
	logic                    accept;

	logic signed [SUM_W-1:0] sum_adj;
	logic signed [SUM_W-1:0] quot;
	logic signed [SAMPLE_W-1:0] pcm_next;
	logic                    clip_next;

	// A tick is taken only when the cell row holds no other tick.
	assign tick.ready = !busy_q;
	assign accept     = tick.valid && !busy_q;

	// The token enters the first cell in the cycle after acceptance; the running sum starts at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok0_q <= '0;
		end else begin
			tok0_q.valid   <= accept;
			tok0_q.restart <= tick.restart;
		end
	end

	assign tok[0] = tok0_q;
	assign sum[0] = '0;

	// Row of tone cells; each one adds its tone to the sum handed on by its left neighbor.
	for (genvar g = 0; g < NUM_TONES; g++) begin : g_cell
		always_comb begin
			cell_cfg[g].data     = cfg_wdata;
			cell_cfg[g].step_we  = cfg_we && (cfg_index[0] == REG_KIND_STEP)
				&& (cfg_index[CFG_IDX_W-1:1] == (CFG_IDX_W - 1)'(g));
			cell_cfg[g].level_we = cfg_we && (cfg_index[0] == REG_KIND_LEVEL)
				&& (cfg_index[CFG_IDX_W-1:1] == (CFG_IDX_W - 1)'(g));
		end

		mtss_tone_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cfg     (cell_cfg[g]),
			.tok_in  (tok[g]),
			.tok_out (tok[g + 1]),
			.sum_in  (sum[g]),
			.sum_out (sum[g + 1]),
			.sum_vld (sum_vld[g])
		);
	end

	// The final sum is ready when the last cell reports it; it stays there until the
	// output register can take it.
	assign res_avail = sum_vld[NUM_TONES - 1] || res_pend_q;
	assign out_load  = res_avail && (!out_vld_q || sample.ready);

	// Division by 2^FRAC_BITS truncating toward zero: negative sums get a bias first.
	assign sum_adj = sum[NUM_TONES][SUM_W-1] ? (sum[NUM_TONES] + ROUND_BIAS) : sum[NUM_TONES];
	assign quot    = sum_adj >>> FRAC_BITS;

	always_comb begin
		if (quot > SAMPLE_MAX) begin
			pcm_next  = SAMPLE_MAX[SAMPLE_W-1:0];
			clip_next = 1'b1;
		end else if (quot < SAMPLE_MIN) begin
			pcm_next  = SAMPLE_MIN[SAMPLE_W-1:0];
			clip_next = 1'b1;
		end else begin
			pcm_next  = quot[SAMPLE_W-1:0];
			clip_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			res_pend_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (out_load) begin
				busy_q <= 1'b0;
			end
			res_pend_q <= res_avail && !out_load;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (sample.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pcm_q  <= pcm_next;
			clip_q <= clip_next;
		end
	end

	assign sample.valid      = out_vld_q;
	assign sample.pcm_sample = pcm_q;
	assign sample.clipped    = clip_q;

endmodule

### tb/tb_top.sv
// Self-checking testbench of the multi-tone sine synthesizer with random ticks and tone setups.
module tb_top;
	import mtss_pkg::*;

	// A tick occupies the block from acceptance until the next tick can be taken.
	localparam int PIPE_LATENCY = NUM_TONES + 3;

	// Ends the run if no request moves on either channel for this many cycles.
	localparam int WATCHDOG_LIMIT = 2000;

	// Q30 coefficients of the odd polynomial that approximates sin(pi/2 * t) on [0, 1].
	localparam longint SINE_POLY [5] = '{
		64'sd1686629713, -64'sd693598670, 64'sd85569306, -64'sd5026995, 64'sd172272
	};
	localparam longint SINE_QUARTER = longint'(1) << (TABLE_BITS - 2);

	// Limits of a signed PCM sample.
	localparam longint PCM_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
	localparam longint PCM_MIN = -(longint'(1) << (SAMPLE_W - 1));

	// Kinds of tone setup that a random phase can program.
	typedef enum int {
		SETUP_RANDOM,
		SETUP_LOUDEST,
		SETUP_SILENT
	} tone_setup_t;

	// Patterns of the sample receiver's ready signal.
	typedef enum int {
		RX_STREAM,
		RX_COIN,
		RX_SPARSE,
		RX_LONG_STALL
	} rx_pattern_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] pcm_sample;
		logic                       clipped;
	} pcm_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	mtss_tick_if   tick_ch ();
	mtss_sample_if sample_ch ();

	multi_tone_sine_synth_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.sample    (sample_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Our own copy of the synthesizer: configured steps and levels, and the phase accumulators.
	bit [PHASE_BITS-1:0] tone_step [NUM_TONES];
	bit [LEVEL_W-1:0]    tone_level [NUM_TONES];
	bit [PHASE_BITS-1:0] phase_acc [NUM_TONES];

	// Restart flags of the tick requests that wait for the driver.
	bit          tick_pending [$];
	// Samples predicted for accepted ticks, oldest first.
	pcm_result_t pcm_expected [$];

	int ticks_queued;
	int samples_seen;
	int fail_count;
	int idle_cycles;

	// Sender burst state and receiver stall state.
	int          burst_left;
	int          gap_left;
	rx_pattern_t rx_pattern;
	int          rx_pattern_left;
	int          rx_stall_left;
	bit [1:0]    rx_cycle;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Full-wave sine table entry k, built by quarter-wave symmetry from the polynomial.
	// Each Q30 product is truncated toward zero, as integer division does.
	function automatic int sine_at(bit [TABLE_BITS-1:0] k);
		bit [1:0] quad;
		longint   x;
		longint   t;
		longint   t2;
		longint   acc;
		longint   s;
		longint   mag;
		int       i;
		quad = k[TABLE_BITS-1 -: 2];
		x    = longint'(k[TABLE_BITS-3:0]);
		if (quad[0]) begin
			x = SINE_QUARTER - x;
		end
		t   = x <<< (32 - TABLE_BITS);
		t2  = (t * t) / Q30_ONE;
		acc = SINE_POLY[4];
		for (i = 3; i >= 0; i--) begin
			acc = SINE_POLY[i] + (acc * t2) / Q30_ONE;
		end
		s = (acc * t) / Q30_ONE;
		if (s < 0) begin
			s = 0;
		end
		mag = (s * AMP_FULL + (Q30_ONE / 2)) / Q30_ONE;
		if (mag > AMP_FULL) begin
			mag = AMP_FULL;
		end
		return quad[1] ? -int'(mag) : int'(mag);
	endfunction

	// Forms the sample for one accepted tick from the current phases, then advances every
	// phase by its step. A restart clears the phases first, so that sample is at time zero.
	function automatic void synth_next_sample(bit restart);
		longint      mix;
		longint      scaled;
		pcm_result_t res;
		int          i;
		mix = 0;
		if (restart) begin
			for (i = 0; i < NUM_TONES; i++) begin
				phase_acc[i] = '0;
			end
		end
		for (i = 0; i < NUM_TONES; i++) begin
			mix += longint'(tone_level[i]) *
				longint'(sine_at(phase_acc[i][PHASE_BITS-1 -: TABLE_BITS]));
			phase_acc[i] += tone_step[i];
		end
		// Signed division truncates toward zero; the saturation then sets the clip flag.
		scaled      = mix / (longint'(1) << FRAC_BITS);
		res.clipped = 1'b0;
		if (scaled > PCM_MAX) begin
			scaled      = PCM_MAX;
			res.clipped = 1'b1;
		end else if (scaled < PCM_MIN) begin
			scaled      = PCM_MIN;
			res.clipped = 1'b1;
		end
		res.pcm_sample = SAMPLE_W'(scaled);
		pcm_expected.push_back(res);
	endfunction

	function automatic logic [CFG_IDX_W-1:0] reg_addr(int tone, logic kind);
		return {(CFG_IDX_W-1)'(tone), kind};
	endfunction

	// Writes one register and mirrors it in our copy. Tones at or beyond NUM_TONES map to
	// indexes the block must ignore. The write enable stays high until end_writes.
	task automatic write_reg(int tone, logic kind, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= reg_addr(tone, kind);
		cfg_wdata <= value;
		if (tone < NUM_TONES) begin
			if (kind == REG_KIND_LEVEL) begin
				tone_level[tone] = value[LEVEL_W-1:0];
			end else begin
				tone_step[tone] = value;
			end
		end
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_tick(bit restart);
		tick_pending.push_back(restart);
		ticks_queued++;
	endtask

	// Holds the stimulus until every queued tick has come back as a sample, then lets the
	// pipeline settle so that register writes land on an idle block.
	task automatic wait_drained();
		while (samples_seen < ticks_queued) begin
			@(posedge clk);
		end
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	// Steps mix fully random values, slow sweeps, exact table strides, small backward steps
	// and audio frequencies at 44.1 kHz.
	function automatic logic [CFG_DATA_W-1:0] random_step();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 32'h000F_FFFF);
			2: return $urandom_range(0, (1 << TABLE_BITS) - 1) << (PHASE_BITS - TABLE_BITS);
			3: return 32'hFFFF_FFFF - $urandom_range(0, 255);
			default: return $urandom_range(20, 20000) * 97391;
		endcase
	endfunction

	// Levels are mostly within unity gain, sometimes above it; the upper half of the write
	// data carries junk that the register must drop.
	function automatic logic [CFG_DATA_W-1:0] random_level();
		logic [LEVEL_W-1:0] lvl;
		case ($urandom_range(0, 5))
			0:       lvl = '0;
			1:       lvl = 16'h8000;
			2:       lvl = LEVEL_W'($urandom_range(0, 65535));
			default: lvl = LEVEL_W'($urandom_range(0, 32768));
		endcase
		return {16'($urandom), lvl};
	endfunction

	task automatic program_tones(tone_setup_t setup);
		int t;
		for (t = 0; t < NUM_TONES; t++) begin
			case (setup)
				SETUP_LOUDEST: begin
					write_reg(t, REG_KIND_STEP, 32'hFFFF_FFFF);
					write_reg(t, REG_KIND_LEVEL, 32'hFFFF_FFFF);
				end
				SETUP_SILENT: begin
					write_reg(t, REG_KIND_STEP, '0);
					write_reg(t, REG_KIND_LEVEL, '0);
				end
				default: begin
					write_reg(t, REG_KIND_STEP, random_step());
					write_reg(t, REG_KIND_LEVEL, random_level());
				end
			endcase
		end
		// Now and then a stray write to an index past the last tone.
		if ($urandom_range(0, 1) == 0) begin
			write_reg($urandom_range(NUM_TONES, 7), 1'($urandom_range(0, 1)), $urandom);
		end
		end_writes();
	endtask

	// Tick driver: presents queued requests in bursts of random length separated by random
	// gaps. While valid is low the restart line carries noise that the block must ignore.
	always @(posedge clk) begin
		bit fire;
		bit nxt_valid;
		bit nxt_restart;
		if (!arst_n) begin
			tick_ch.valid   <= 1'b0;
			tick_ch.restart <= 1'b0;
		end else begin
			fire        = tick_ch.valid && tick_ch.ready;
			nxt_valid   = tick_ch.valid;
			nxt_restart = tick_ch.restart;
			// The request just accepted updates our copy of the phases at once.
			if (fire) begin
				synth_next_sample(tick_ch.restart);
			end
			if (fire || !tick_ch.valid) begin
				nxt_valid   = 1'b0;
				nxt_restart = 1'($urandom_range(0, 1));
				if (gap_left > 0) begin
					gap_left--;
				end else if (tick_pending.size() > 0) begin
					nxt_valid   = 1'b1;
					nxt_restart = tick_pending.pop_front();
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						// A third of the bursts run straight into the next one.
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
			tick_ch.valid   <= nxt_valid;
			tick_ch.restart <= nxt_restart;
		end
	end

	// Sample monitor: checks every accepted sample against the oldest prediction and drives
	// the receiver's ready on a random pattern that is drawn anew when its run length ends.
	always @(posedge clk) begin
		pcm_result_t want;
		bit          nxt_ready;
		if (!arst_n) begin
			sample_ch.ready <= 1'b0;
		end else begin
			if (sample_ch.valid && sample_ch.ready) begin
				samples_seen++;
				if (pcm_expected.size() == 0) begin
					$error("unexpected sample: pcm_sample %0d, clipped %0b",
						sample_ch.pcm_sample, sample_ch.clipped);
					fail_count++;
				end else begin
					want = pcm_expected.pop_front();
					if (sample_ch.pcm_sample !== want.pcm_sample) begin
						$error("pcm_sample: expected %0d, got %0d",
							want.pcm_sample, sample_ch.pcm_sample);
						fail_count++;
					end
					if (sample_ch.clipped !== want.clipped) begin
						$error("clipped: expected %0b, got %0b",
							want.clipped, sample_ch.clipped);
						fail_count++;
					end
				end
			end
			if (rx_pattern_left == 0) begin
				rx_pattern      = rx_pattern_t'($urandom_range(0, 3));
				rx_pattern_left = $urandom_range(16, 96);
			end else begin
				rx_pattern_left--;
			end
			rx_cycle++;
			case (rx_pattern)
				RX_STREAM: nxt_ready = 1'b1;
				RX_COIN:   nxt_ready = 1'($urandom_range(0, 1));
				RX_SPARSE: nxt_ready = (rx_cycle == 2'b00);
				default: begin
					if (rx_stall_left > 0) begin
						rx_stall_left--;
						nxt_ready = 1'b0;
					end else begin
						nxt_ready = 1'b1;
						if ($urandom_range(0, 7) == 0) begin
							rx_stall_left = $urandom_range(5, 25);
						end
					end
				end
			endcase
			sample_ch.ready <= nxt_ready;
		end
	end

	// Watchdog: a hung handshake on either side ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((tick_ch.valid && tick_ch.ready) || (sample_ch.valid && sample_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	initial begin
		int phase;
		int n;
		int k;
		int rate;
		int t;
		clk             = 1'b0;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		tick_ch.valid   = 1'b0;
		tick_ch.restart = 1'b0;
		sample_ch.ready = 1'b0;
		ticks_queued    = 0;
		samples_seen    = 0;
		fail_count      = 0;
		idle_cycles     = 0;
		burst_left      = 1;
		gap_left        = 0;
		rx_pattern      = RX_STREAM;
		rx_pattern_left = 0;
		rx_stall_left   = 0;
		rx_cycle        = '0;
		for (t = 0; t < NUM_TONES; t++) begin
			tone_step[t]  = '0;
			tone_level[t] = '0;
			phase_acc[t]  = '0;
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. With every register at its reset value the output is silent.
		send_tick(1'b0);
		send_tick(1'b1);
		wait_drained();

		// Tone 0 alone at unity gain, a quarter turn per sample: zero, the positive peak,
		// zero, the negative peak, and then the phase wraps back to zero.
		write_reg(0, REG_KIND_STEP, 32'h4000_0000);
		write_reg(0, REG_KIND_LEVEL, 32'h0000_8000);
		end_writes();
		send_tick(1'b1);
		repeat (4) send_tick(1'b0);
		wait_drained();

		// All tones in phase at the largest level, written with junk above the level bits:
		// the peaks saturate at both ends of the range.
		for (t = 0; t < NUM_TONES; t++) begin
			write_reg(t, REG_KIND_STEP, 32'h4000_0000);
			write_reg(t, REG_KIND_LEVEL, 32'hA5A5_FFFF);
		end
		end_writes();
		send_tick(1'b1);
		repeat (3) send_tick(1'b0);
		wait_drained();

		// Steps near the largest value run every phase backwards. Writes past the last tone must
		// leave the tones alone, and a restart in the middle returns to time zero.
		for (t = 0; t < NUM_TONES; t++) begin
			write_reg(t, REG_KIND_STEP, 32'hFFFF_FFFF - 32'(t) * 32'h0100_0000);
			write_reg(t, REG_KIND_LEVEL, 32'h0000_8000 >> t);
		end
		for (t = NUM_TONES; t < 8; t++) begin
			write_reg(t, REG_KIND_STEP, 32'h1234_5678);
			write_reg(t, REG_KIND_LEVEL, 32'h0000_FFFF);
		end
		end_writes();
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
		wait_drained();

		// Random part: each phase programs a new tone setup on an idle block and then
		// streams ticks with an occasional restart. The sender waits for the last sample of
		// each phase before the registers change, so the pipeline empties completely.
		for (phase = 0; phase < 10; phase++) begin
			case (phase)
				2:       program_tones(SETUP_LOUDEST);
				5:       program_tones(SETUP_SILENT);
				default: program_tones(SETUP_RANDOM);
			endcase
			n    = $urandom_range(100, 130);
			rate = $urandom_range(0, 20);
			send_tick(1'($urandom_range(0, 1)));
			for (k = 1; k < n; k++) begin
				send_tick($urandom_range(0, 99) < rate);
			end
			wait_drained();
		end

		// Let any stray sample show up before the verdict.
		repeat (4 * PIPE_LATENCY) @(posedge clk);
		if (pcm_expected.size() != 0) begin
			$error("%0d predicted samples never arrived", pcm_expected.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
